// File: hw/rtl/shell_command_tokenizer_core_assert.svh
// Assertion macros for the tokenizer RTL, used by the result queue.
// With SYNTH defined the macros expand to nothing.
`ifndef SHELL_COMMAND_TOKENIZER_CORE_ASSERT_SVH
`define SHELL_COMMAND_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTH
`define SCT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tokenizer assertion failed");
`define SCT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tokenizer forbidden condition");
`else
`define SCT_ASSERT(lbl, clk, rst_n, prop)
`define SCT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/sct_pkg.sv
package sct_pkg;

	localparam int MAX_WORD_LEN = 64;
	localparam int CNT_W        = $clog2(MAX_WORD_LEN);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS  = 3;

	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_SQ     = 3'd1,
		MODE_DQ     = 3'd2,
		MODE_DQ_ESC = 3'd3,
		MODE_BSL    = 3'd4,
		MODE_GT     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KIND_CHAR = 3'd0,
		KIND_DONE = 3'd1,
		KIND_PIPE = 3'd2,
		KIND_IN   = 3'd3,
		KIND_OUT  = 3'd4,
		KIND_APP  = 3'd5,
		KIND_BG   = 3'd6,
		KIND_END  = 3'd7
	} kind_t;

	// All results caused by one input beat, in emission order.
	typedef struct packed {
		logic [1:0]  count;
		kind_t [2:0] kinds;
		logic [7:0]  char_value;
	} entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

endpackage

// File: hw/rtl/sct_front.sv
module sct_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        text_byte,
	input  logic              is_end,
	output logic              push,
	output sct_pkg::entry_t   push_entry
);

	sct_pkg::mode_t              mode_q, mode_d;
	logic [sct_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_after;

	logic        end_item, ws, do_plain;
	logic        want_char, char_add, finish, f_out, f_done, op_en, f_end;
	sct_pkg::kind_t op_kind;
	logic [4:0]  slot_en;
	sct_pkg::kind_t slot_kind [5];
	logic [1:0]  n;

	assign end_item = is_end || (text_byte == sct_pkg::CH_NUL);
	assign ws       = text_byte inside {8'h20, [8'h09:8'h0D]};
	// Plain handling covers plain mode, the unused codes, and a byte after '>'
	// that is not a second '>'.
	assign do_plain = !end_item &&
		((mode_q == sct_pkg::MODE_GT && text_byte != sct_pkg::CH_GT) ||
		 !(mode_q inside {sct_pkg::MODE_SQ, sct_pkg::MODE_DQ, sct_pkg::MODE_DQ_ESC,
			sct_pkg::MODE_BSL, sct_pkg::MODE_GT}));

	// Next mode.
	always_comb begin
		mode_d = sct_pkg::MODE_PLAIN;
		if (!end_item) begin
			case (mode_q)
				sct_pkg::MODE_SQ: begin
					mode_d = (text_byte == sct_pkg::CH_SQUOT) ? sct_pkg::MODE_PLAIN
						: sct_pkg::MODE_SQ;
				end
				sct_pkg::MODE_DQ: begin
					if (text_byte == sct_pkg::CH_DQUOT) begin
						mode_d = sct_pkg::MODE_PLAIN;
					end else if (text_byte == sct_pkg::CH_BSL) begin
						mode_d = sct_pkg::MODE_DQ_ESC;
					end else begin
						mode_d = sct_pkg::MODE_DQ;
					end
				end
				sct_pkg::MODE_DQ_ESC: mode_d = sct_pkg::MODE_DQ;
				sct_pkg::MODE_BSL:    mode_d = sct_pkg::MODE_PLAIN;
				default: begin
					if (do_plain) begin
						case (text_byte)
							sct_pkg::CH_GT:    mode_d = sct_pkg::MODE_GT;
							sct_pkg::CH_SQUOT: mode_d = sct_pkg::MODE_SQ;
							sct_pkg::CH_DQUOT: mode_d = sct_pkg::MODE_DQ;
							sct_pkg::CH_BSL:   mode_d = sct_pkg::MODE_BSL;
							default:           mode_d = sct_pkg::MODE_PLAIN;
						endcase
					end
				end
			endcase
		end
	end

	// Token decisions for this beat.
	always_comb begin
		want_char = 1'b0;
		finish    = 1'b0;
		f_out     = 1'b0;
		op_en     = 1'b0;
		op_kind   = sct_pkg::KIND_PIPE;
		f_end     = 1'b0;
		if (end_item) begin
			f_end  = 1'b1;
			finish = 1'b1;
			if (mode_q == sct_pkg::MODE_BSL || mode_q == sct_pkg::MODE_DQ_ESC) begin
				want_char = 1'b1;
			end else if (mode_q == sct_pkg::MODE_GT) begin
				f_out = 1'b1;
			end
		end else begin
			case (mode_q)
				sct_pkg::MODE_SQ:     want_char = text_byte != sct_pkg::CH_SQUOT;
				sct_pkg::MODE_DQ:     want_char = text_byte != sct_pkg::CH_DQUOT &&
					text_byte != sct_pkg::CH_BSL;
				sct_pkg::MODE_DQ_ESC: want_char = 1'b1;
				sct_pkg::MODE_BSL:    want_char = !ws;
				sct_pkg::MODE_GT: begin
					if (text_byte == sct_pkg::CH_GT) begin
						op_en   = 1'b1;
						op_kind = sct_pkg::KIND_APP;
					end else begin
						f_out = 1'b1;
					end
				end
				default: ;
			endcase
			if (do_plain) begin
				if (ws) begin
					finish = 1'b1;
				end else begin
					case (text_byte)
						sct_pkg::CH_PIPE: begin
							finish  = 1'b1;
							op_en   = 1'b1;
							op_kind = sct_pkg::KIND_PIPE;
						end
						sct_pkg::CH_LT: begin
							finish  = 1'b1;
							op_en   = 1'b1;
							op_kind = sct_pkg::KIND_IN;
						end
						sct_pkg::CH_AMP: begin
							finish  = 1'b1;
							op_en   = 1'b1;
							op_kind = sct_pkg::KIND_BG;
						end
						sct_pkg::CH_GT:    finish = 1'b1;
						sct_pkg::CH_SQUOT,
						sct_pkg::CH_DQUOT,
						sct_pkg::CH_BSL:   ;
						default:           want_char = 1'b1;
					endcase
				end
			end
		end
	end

	// Characters past the word limit are dropped and the count holds.
	assign char_add  = want_char && (cnt_q < sct_pkg::CNT_W'(sct_pkg::MAX_WORD_LEN - 1));
	assign cnt_after = cnt_q + sct_pkg::CNT_W'(char_add);
	assign f_done    = finish && (cnt_after != '0);
	assign cnt_d     = finish ? '0 : cnt_after;

	// Results always appear in this fixed order; at most three are present.
	always_comb begin
		slot_en      = {f_end, op_en, f_done, char_add, f_out};
		slot_kind[0] = sct_pkg::KIND_OUT;
		slot_kind[1] = sct_pkg::KIND_CHAR;
		slot_kind[2] = sct_pkg::KIND_DONE;
		slot_kind[3] = op_kind;
		slot_kind[4] = sct_pkg::KIND_END;
		n = 2'd0;
		push_entry.kinds = {3{sct_pkg::KIND_END}};
		for (int i = 0; i < 5; i++) begin
			if (slot_en[i] && n != 2'(sct_pkg::MAX_RESULTS)) begin
				push_entry.kinds[n] = slot_kind[i];
				n = n + 2'd1;
			end
		end
		push_entry.count      = n;
		push_entry.char_value = end_item ? sct_pkg::CH_BSL : text_byte;
	end

	assign push = accept && (push_entry.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sct_pkg::MODE_PLAIN;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// File: hw/rtl/sct_queue.sv
`include "shell_command_tokenizer_core_assert.svh"

module sct_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sct_pkg::entry_t     push_entry,
	input  logic                pop,
	output sct_pkg::entry_t     head,
	output sct_pkg::q_status_t  status
);

	sct_pkg::entry_t             slots_q [sct_pkg::QUEUE_DEPTH];
	logic [sct_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sct_pkg::QCNT_W-1:0] count_q;

	assign head             = slots_q[rd_ptr_q];
	assign status.not_empty = count_q != '0;
	assign status.full      = count_q == sct_pkg::QCNT_W'(sct_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sct_pkg::QPTR_W'(sct_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + sct_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sct_pkg::QPTR_W'(sct_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + sct_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + sct_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - sct_pkg::QCNT_W'(1);
			end
		end
	end

	`SCT_ASSERT(a_count_inc, clk, arst_n, push && !pop |=> count_q == $past(count_q) + sct_pkg::QCNT_W'(1))
	`SCT_ASSERT(a_count_dec, clk, arst_n, pop && !push |=> count_q == $past(count_q) - sct_pkg::QCNT_W'(1))
	`SCT_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && count_q == '0)
	`SCT_ASSERT_NEVER(a_push_full, clk, arst_n, push && !pop && status.full)

endmodule

// File: hw/rtl/sct_back.sv
module sct_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sct_pkg::entry_t     head,
	input  sct_pkg::q_status_t  status,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic [2:0]          m_tuser,
	output logic                m_tlast
);

	logic [1:0]     idx_q;
	logic           m_tvalid_q, m_tlast_q;
	logic [7:0]     m_tdata_q;
	sct_pkg::kind_t m_tuser_q, cur_kind;
	logic           load, at_last;

	assign cur_kind = head.kinds[idx_q];
	assign at_last  = idx_q == 2'(head.count - 2'd1);
	assign load     = status.not_empty && (!m_tvalid_q || m_tready);
	assign pop      = load && at_last;

	always_ff @(posedge clk) begin
		if (load) begin
			m_tuser_q <= cur_kind;
			m_tdata_q <= (cur_kind == sct_pkg::KIND_CHAR) ? head.char_value : 8'h00;
			m_tlast_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				idx_q      <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: hw/rtl/shell_command_tokenizer_core.sv
// Shell command-line tokenizer. Bytes enter on the s_ stream, one beat per
// cycle whenever the four-entry result queue has room; a beat with s_tuser set,
// or a zero byte, ends the line. The front end updates the quoting mode and the
// word length in the cycle a beat is taken and queues the zero to three tokens
// it causes. The back end sends one token per cycle while m_tready is high, from
// a registered output; a beat's tokens leave in turn, each through the queue and
// then the output register. The output serializer sets the sustained rate: one
// token per cycle, which is one beat per cycle for beats that cause at most one
// token. Beats that cause no token never touch the queue.
module shell_command_tokenizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] text_byte
	input  logic       s_tuser,  // [0] is_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] char_value
	output logic [2:0] m_tuser,  // [2:0] token_kind
	output logic       m_tlast   // last_of_run
);

	logic               push, pop;
	sct_pkg::entry_t    push_entry, head;
	sct_pkg::q_status_t status;

	assign s_tready = !status.full;

	sct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_tvalid && s_tready),
		.text_byte  (s_tdata),
		.is_end     (s_tuser),
		.push       (push),
		.push_entry (push_entry)
	);

	sct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	sct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sct_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam int STALL_LIMIT      = 2000;
	localparam int HOLD_CYCLES      = 150;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} token_t;

	typedef struct {
		logic [7:0] b;
		logic       fin;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // [7:0] text_byte
	logic       s_tuser = 1'b0;   // [0] is_end
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] char_value
	logic [2:0] m_tuser;          // [2:0] token_kind
	logic       m_tlast;

	beat_t  pend_q[$];
	token_t token_q[$];
	token_t beat_toks[$];

	mode_t quote_mode = MODE_PLAIN;
	int    word_len = 0;

	int items_pushed = 0;
	int items_acc = 0;
	int errors = 0;
	int stall_cycles = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 66;
	int hold_left = 0;
	bit hold_go = 1'b0;
	bit hold_used = 1'b0;
	bit beat_taken = 1'b0;

	shell_command_tokenizer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// ---------------- token prediction ----------------

	task automatic put_tok(input kind_t k, input logic [7:0] c);
		token_t t;
		if (beat_toks.size() < MAX_RESULTS) begin
			t.kind = k;
			t.ch = (k == KIND_CHAR) ? c : 8'h00;
			t.last = 1'b0;
			beat_toks.push_back(t);
		end
	endtask

	task automatic add_word_char(input logic [7:0] c);
		// Characters past the length limit are dropped and the count holds.
		if (word_len < MAX_WORD_LEN - 1) begin
			word_len++;
			put_tok(KIND_CHAR, c);
		end
	endtask

	task automatic close_word();
		if (word_len > 0)
			put_tok(KIND_DONE, 8'h00);
		word_len = 0;
	endtask

	task automatic plain_byte(input logic [7:0] c);
		if (is_blank(c)) begin
			close_word();
		end else if (c == CH_PIPE) begin
			close_word();
			put_tok(KIND_PIPE, 8'h00);
		end else if (c == CH_LT) begin
			close_word();
			put_tok(KIND_IN, 8'h00);
		end else if (c == CH_AMP) begin
			close_word();
			put_tok(KIND_BG, 8'h00);
		end else if (c == CH_GT) begin
			close_word();
			quote_mode = MODE_GT;
		end else if (c == CH_SQUOT) begin
			quote_mode = MODE_SQ;
		end else if (c == CH_DQUOT) begin
			quote_mode = MODE_DQ;
		end else if (c == CH_BSL) begin
			quote_mode = MODE_BSL;
		end else begin
			add_word_char(c);
		end
	endtask

	task automatic tokenize_beat(input logic [7:0] c, input logic fin);
		token_t t;
		beat_toks.delete();
		if (fin || c == CH_NUL) begin
			if (quote_mode == MODE_BSL || quote_mode == MODE_DQ_ESC)
				add_word_char(CH_BSL);
			else if (quote_mode == MODE_GT)
				put_tok(KIND_OUT, 8'h00);
			close_word();
			put_tok(KIND_END, 8'h00);
			quote_mode = MODE_PLAIN;
			word_len = 0;
		end else begin
			case (quote_mode)
				MODE_SQ: begin
					if (c == CH_SQUOT)
						quote_mode = MODE_PLAIN;
					else
						add_word_char(c);
				end
				MODE_DQ: begin
					if (c == CH_DQUOT)
						quote_mode = MODE_PLAIN;
					else if (c == CH_BSL)
						quote_mode = MODE_DQ_ESC;
					else
						add_word_char(c);
				end
				MODE_DQ_ESC: begin
					add_word_char(c);
					quote_mode = MODE_DQ;
				end
				MODE_BSL: begin
					quote_mode = MODE_PLAIN;
					if (!is_blank(c))
						add_word_char(c);
				end
				MODE_GT: begin
					quote_mode = MODE_PLAIN;
					if (c == CH_GT) begin
						put_tok(KIND_APP, 8'h00);
					end else begin
						put_tok(KIND_OUT, 8'h00);
						plain_byte(c);
					end
				end
				default: begin
					quote_mode = MODE_PLAIN;
					plain_byte(c);
				end
			endcase
		end
		if (beat_toks.size() > 0) begin
			t = beat_toks.pop_back();
			t.last = 1'b1;
			beat_toks.push_back(t);
		end
		foreach (beat_toks[i])
			token_q.push_back(beat_toks[i]);
	endtask

	// ---------------- stimulus generation ----------------

	task automatic push_item(input logic [7:0] b, input logic fin);
		beat_t it;
		it.b = b;
		it.fin = fin;
		pend_q.push_back(it);
		items_pushed++;
	endtask

	// A byte that plain mode keeps as a word character.
	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) == 0)
				b = 8'($urandom_range(1, 255));
			else
				b = 8'($urandom_range(8'h61, 8'h7A));
		end while (is_blank(b) || b == CH_PIPE || b == CH_LT || b == CH_GT || b == CH_AMP ||
			b == CH_SQUOT || b == CH_DQUOT || b == CH_BSL);
		return b;
	endfunction

	function automatic logic [7:0] nz_byte_except(input logic [7:0] x);
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == x);
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		if ($urandom_range(0, 1) == 0)
			return CH_SPACE;
		return 8'($urandom_range(CH_TAB, CH_CR));
	endfunction

	task automatic end_line();
		if ($urandom_range(0, 3) == 0)
			push_item(CH_NUL, 1'b0);
		else
			push_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic gen_line();
		int nseg;
		int n;
		logic [7:0] ops[5];
		ops = '{CH_PIPE, CH_LT, CH_AMP, CH_SQUOT, CH_DQUOT};
		nseg = $urandom_range(1, 6);
		if ($urandom_range(0, 9) == 0) begin
			// Noise: arbitrary nonzero bytes.
			n = $urandom_range(1, 8);
			repeat (n) push_item(8'($urandom_range(1, 255)), 1'b0);
		end else begin
			repeat (nseg) begin
				case ($urandom_range(0, 8))
					0, 1: begin
						n = $urandom_range(1, 5);
						repeat (n) push_item(word_byte(), 1'b0);
					end
					2: begin
						n = $urandom_range(1, 2);
						repeat (n) push_item(blank_byte(), 1'b0);
					end
					3: begin
						case ($urandom_range(0, 4))
							0: push_item(CH_PIPE, 1'b0);
							1: push_item(CH_LT, 1'b0);
							2: push_item(CH_AMP, 1'b0);
							3: push_item(CH_GT, 1'b0);
							default: begin
								push_item(CH_GT, 1'b0);
								push_item(CH_GT, 1'b0);
							end
						endcase
					end
					4: begin
						push_item(CH_SQUOT, 1'b0);
						n = $urandom_range(0, 4);
						repeat (n) push_item(nz_byte_except(CH_SQUOT), 1'b0);
						if ($urandom_range(0, 9) != 0)
							push_item(CH_SQUOT, 1'b0);
					end
					5: begin
						push_item(CH_DQUOT, 1'b0);
						n = $urandom_range(0, 4);
						repeat (n) begin
							if ($urandom_range(0, 2) == 0) begin
								push_item(CH_BSL, 1'b0);
								push_item(8'($urandom_range(1, 255)), 1'b0);
							end else begin
								push_item(nz_byte_except(CH_DQUOT), 1'b0);
							end
						end
						if ($urandom_range(0, 9) != 0)
							push_item(CH_DQUOT, 1'b0);
					end
					6: begin
						push_item(CH_BSL, 1'b0);
						if ($urandom_range(0, 1) == 0)
							push_item(blank_byte(), 1'b0);
						else
							push_item(8'($urandom_range(1, 255)), 1'b0);
					end
					7: push_item(CH_BSL, 1'b0);
					default: begin
						push_item(CH_GT, 1'b0);
						if ($urandom_range(0, 2) == 0)
							push_item(word_byte(), 1'b0);
						else
							push_item(ops[$urandom_range(0, 4)], 1'b0);
					end
				endcase
			end
		end
		end_line();
	endtask

	// One word longer than the limit, partly quoted and escaped.
	task automatic gen_long_word();
		int target;
		int cnt;
		target = MAX_WORD_LEN + $urandom_range(0, 6);
		cnt = 0;
		while (cnt < target) begin
			case ($urandom_range(0, 5))
				0: begin
					push_item(CH_SQUOT, 1'b0);
					push_item(word_byte(), 1'b0);
					push_item(CH_SQUOT, 1'b0);
				end
				1: begin
					push_item(CH_BSL, 1'b0);
					push_item(word_byte(), 1'b0);
				end
				default: push_item(word_byte(), 1'b0);
			endcase
			cnt++;
		end
		push_item(CH_PIPE, 1'b0);
		end_line();
	endtask

	task automatic gen_random(input int count);
		int stop;
		stop = items_pushed + count;
		while (items_pushed < stop)
			gen_line();
	endtask

	task automatic wait_drained();
		while (items_acc != items_pushed)
			@(posedge clk);
	endtask

	// ---------------- driver, receiver, monitor ----------------

	always @(negedge clk) begin : drive_bytes
		logic       nv;
		logic [7:0] nd;
		logic       nu;
		beat_t      it;
		nv = s_tvalid;
		nd = s_tdata;
		nu = s_tuser;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!s_tvalid || beat_taken) begin
			if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				it = pend_q.pop_front();
				nv = 1'b1;
				nd = it.b;
				nu = it.fin;
			end else begin
				nv = 1'b0;
			end
		end
		beat_taken = 1'b0;
		s_tvalid <= nv;
		s_tdata <= nd;
		s_tuser <= nu;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			// Long back-pressure so the result queue fills and the input stalls.
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watch_tokens
		token_t exp_t;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tokenize_beat(s_tdata, s_tuser);
				beat_taken = 1'b1;
				items_acc++;
			end
			if (m_tvalid && m_tready) begin
				if (token_q.size() == 0) begin
					$display("%0t: unexpected token: kind %0d char %h last %b",
						$time, m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					exp_t = token_q.pop_front();
					if (exp_t.kind !== m_tuser || exp_t.ch !== m_tdata ||
						exp_t.last !== m_tlast) begin
						$display("%0t: token mismatch: expected kind %0d char %h last %b, got kind %0d char %h last %b",
							$time, exp_t.kind, exp_t.ch, exp_t.last, m_tuser, m_tdata,
							m_tlast);
						errors++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("shell_command_tokenizer_core test failed");
				$finish;
			end
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Operators, extreme bytes, append, pending '>' followed by a word.
		push_item(8'h61, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(CH_TAB, 1'b0);
		push_item(CH_PIPE, 1'b0);
		push_item(CH_LT, 1'b0);
		push_item(CH_AMP, 1'b0);
		push_item(CH_GT, 1'b0);
		push_item(CH_GT, 1'b0);
		push_item(CH_GT, 1'b0);
		push_item(8'h78, 1'b0);
		push_item(8'hFF, 1'b1);
		// Empty quotes give no word-done; escaped quote inside double quotes;
		// a pending '>' at the end of the line.
		push_item(CH_SQUOT, 1'b0);
		push_item(CH_SQUOT, 1'b0);
		push_item(CH_SPACE, 1'b0);
		push_item(CH_DQUOT, 1'b0);
		push_item(CH_BSL, 1'b0);
		push_item(CH_DQUOT, 1'b0);
		push_item(CH_DQUOT, 1'b0);
		push_item(CH_GT, 1'b0);
		push_item(8'h01, 1'b1);
		// Backslash before a blank is skipped; a trailing backslash is kept.
		push_item(CH_BSL, 1'b0);
		push_item(CH_SPACE, 1'b0);
		push_item(CH_BSL, 1'b0);
		push_item(CH_NUL, 1'b0);
		// Unterminated double quote ending on an escape.
		push_item(CH_DQUOT, 1'b0);
		push_item(CH_BSL, 1'b0);
		push_item(CH_NUL, 1'b1);

		gen_random(40);
		wait_drained();

		send_idle_pct = 66;
		recv_idle_pct = 25;
		gen_random(40);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go = 1'b1;
		gen_long_word();
		gen_random(40);
		wait_drained();

		while (token_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("shell_command_tokenizer_core test passed");
		else
			$display("shell_command_tokenizer_core test failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sct_pkg.sv
hw/rtl/sct_front.sv
hw/rtl/sct_queue.sv
hw/rtl/sct_back.sv
hw/rtl/shell_command_tokenizer_core.sv
tb/tb.sv
